// ===== design/b64enc_pkg.sv =====
// Package for the base64 stream encoder.
// Holds the alphabet lookup and shared widths; no dependencies.
package b64enc_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned GroupW = 6;
  localparam int unsigned MaxChars = 3;

  localparam logic [CharW-1:0] CharNul = 7'h00;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [CharW-1:0] b64_char(input logic [GroupW-1:0] grp);
    logic [CharW-1:0] g;
    g = {1'b0, grp};
    if (grp < 6'd26) begin
      b64_char = 7'h41 + g;
    end else if (grp < 6'd52) begin
      b64_char = 7'h61 + (g - 7'd26);
    end else if (grp < 6'd62) begin
      b64_char = 7'h30 + (g - 7'd52);
    end else if (grp == 6'd62) begin
      b64_char = 7'h2B;
    end else begin
      b64_char = 7'h2F;
    end
  endfunction

endpackage

// ===== design/base64_stream_encoder_core.sv =====
// Base64 stream encoder, no padding, NUL-terminated runs.
// Depends on b64enc_pkg (alphabet lookup, widths).
//
// channel | dir | tdata                  | tlast
// in_     | in  | [7:0] data_byte        | last_byte
// out_    | out | [6:0] out_char, [7] 0  | run_last
//
// Each input transfer is encoded combinationally and registered into a
// character buffer of up to three entries, which drains one character per
// cycle into the output register while the output is not stalled. An item
// yields 1 to 3 characters (2 at most for non-last bytes). A new byte is
// taken in the cycle the buffer's final character moves to the output
// register. rst_n is synchronous, active low; output stalls hold the output
// register and back up into the buffer and in_tready.
module base64_stream_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast   // run_last
);
  import b64enc_pkg::*;

  typedef enum logic [1:0] {PH0, PH2, PH4} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [GroupW-1:0] bits_r, bits_nxt;

  logic [CharW-1:0]  ch_r   [MaxChars];
  logic              lst_r  [MaxChars];
  logic [1:0]        cnt_r;

  logic [CharW-1:0]  ch_nxt  [MaxChars];
  logic              lst_nxt [MaxChars];
  logic [1:0]        cnt_nxt;

  logic              out_valid_r;
  logic [CharW-1:0]  out_char_r;
  logic              out_last_r;

  logic              in_xfer;
  logic              out_load;
  logic [DataW-1:0]  b;
  logic [1:0]        n;

  assign out_load  = (cnt_r != 2'd0) && (!out_valid_r || out_tready);
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_load);
  assign in_xfer   = in_tvalid && in_tready;
  assign b         = in_tdata;

  always_comb begin
    for (int i = 0; i < MaxChars; i++) begin
      ch_nxt[i]  = CharNul;
      lst_nxt[i] = 1'b0;
    end
    n = 2'd1;
    unique case (phase_r)
      PH2: begin
        ch_nxt[0] = b64_char(bits_r | {2'b00, b[7:4]});
        bits_nxt  = {b[3:0], 2'b00};
        phase_nxt = PH4;
      end
      PH4: begin
        ch_nxt[0] = b64_char(bits_r | {4'b0000, b[7:6]});
        ch_nxt[1] = b64_char(b[5:0]);
        bits_nxt  = '0;
        phase_nxt = PH0;
        n         = 2'd2;
      end
      default: begin
        ch_nxt[0] = b64_char(b[7:2]);
        bits_nxt  = {b[1:0], 4'b0000};
        phase_nxt = PH2;
      end
    endcase
    if (in_tlast) begin
      if (phase_nxt != PH0) begin
        ch_nxt[1] = b64_char(bits_nxt);
        n         = 2'd2;
      end
      if (n == 2'd2) begin
        lst_nxt[2] = 1'b1;
      end else begin
        lst_nxt[1] = 1'b1;
      end
      n         = n + 2'd1;
      bits_nxt  = '0;
      phase_nxt = PH0;
    end
    cnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH0;
      bits_r      <= '0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r <= phase_nxt;
        bits_r  <= bits_nxt;
        cnt_r   <= cnt_nxt;
        for (int i = 0; i < MaxChars; i++) begin
          ch_r[i]  <= ch_nxt[i];
          lst_r[i] <= lst_nxt[i];
        end
      end else if (out_load) begin
        cnt_r <= cnt_r - 2'd1;
        for (int i = 0; i < MaxChars - 1; i++) begin
          ch_r[i]  <= ch_r[i+1];
          lst_r[i] <= lst_r[i+1];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_char_r  <= ch_r[0];
        out_last_r  <= lst_r[0];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule
